>>> sv/log_token_bucket_limiter_top_macros.svh
// Assertion macros for the log token bucket limiter checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef LOG_TOKEN_BUCKET_LIMITER_TOP_MACROS_SVH
`define LOG_TOKEN_BUCKET_LIMITER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTBL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltbl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LTBL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltbl assertion failed");

`endif

>>> sv/ltbl_pkg.sv
// Shared types and constants of the log token bucket limiter.
// Used by the core, the output sequencer, the top level and the checker.
package ltbl_pkg;

    localparam int ONE_TOKEN = 1000;

    localparam int NOW_W   = 32;
    localparam int LEVEL_W = 3;
    localparam int COUNT_W = 32;
    localparam int BURST_W = 11;
    localparam int RATE_W  = 10;
    localparam int CAP_W   = 21;
    localparam int TDATA_W = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [2:0] {
        KIND_PASS,
        KIND_DROP,
        KIND_NOTICE,
        KIND_COUNT,
        KIND_FILTER
    } kind_t;

    typedef enum logic [1:0] {
        REG_LEVEL_FLOOR,
        REG_BURST_TOKENS,
        REG_RATE_PER_SECOND
    } reg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_floor;
        logic [BURST_W-1:0] burst_tokens;
        logic [RATE_W-1:0]  rate_per_second;
    } ltbl_cfg_t;

    // Results of one request. A triple bundle expands to notice, count, pass.
    typedef struct packed {
        logic               triple;
        kind_t              kind;
        logic [COUNT_W-1:0] count;
        logic [LEVEL_W-1:0] sev;
    } ltbl_bundle_t;

endpackage

>>> sv/log_token_bucket_limiter_top.sv
// Top level of the log token bucket limiter: ports, configuration registers
// and input register. Depends on ltbl_pkg, ltbl_core and ltbl_out_seq.
//
// One request is accepted per clock cycle unless the output stalls; it waits in
// the input register, and its results leave from the output register. A request
// that pays for a suppression report yields three results (notice, count, pass)
// and holds the single output port for all three, one result per cycle while
// tready is high, so the sustained rate is one request per cycle for one-result
// requests, else set by the output port. Config writes are taken in every cycle.
module log_token_bucket_limiter_top
    import ltbl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,   // now_ms[31:0], level[34:32]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,   // count[31:0], severity[34:32]
    output logic                  m_axis_tlast,
    output logic [2:0]            m_axis_tuser,   // kind[2:0]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ltbl_cfg_t          cfg_reg;
    logic               in_valid_reg;
    logic [NOW_W-1:0]   in_now_reg;
    logic [LEVEL_W-1:0] in_level_reg;
    logic               free;
    logic               load;
    logic               s_fire;
    ltbl_bundle_t       bundle;

    assign cfg_ready     = 1'b1;
    assign load          = in_valid_reg && free;
    assign s_axis_tready = !in_valid_reg || free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_floor     <= LEVEL_W'(1);
            cfg_reg.burst_tokens    <= BURST_W'(10);
            cfg_reg.rate_per_second <= RATE_W'(20);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEVEL_FLOOR:     cfg_reg.level_floor     <= cfg_data[LEVEL_W-1:0];
                REG_BURST_TOKENS:    cfg_reg.burst_tokens    <= cfg_data[BURST_W-1:0];
                REG_RATE_PER_SECOND: cfg_reg.rate_per_second <= cfg_data[RATE_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_fire)
            in_valid_reg <= 1'b1;
        else if (load)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_now_reg   <= s_axis_tdata[NOW_W-1:0];
            in_level_reg <= s_axis_tdata[NOW_W+LEVEL_W-1:NOW_W];
        end
    end

    ltbl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .go     (load),
        .now_ms (in_now_reg),
        .level  (in_level_reg),
        .bundle (bundle)
    );

    ltbl_out_seq u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .bundle (bundle),
        .free   (free),
        .tvalid (m_axis_tvalid),
        .tready (m_axis_tready),
        .tdata  (m_axis_tdata),
        .tlast  (m_axis_tlast),
        .tuser  (m_axis_tuser)
    );

endmodule

>>> sv/ltbl_core.sv
// Bucket state and per-request decision of the log token bucket limiter.
// Depends on ltbl_pkg for the configuration and result bundle types.
module ltbl_core
    import ltbl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ltbl_cfg_t          cfg,
    input  logic               go,
    input  logic [NOW_W-1:0]   now_ms,
    input  logic [LEVEL_W-1:0] level,
    output ltbl_bundle_t       bundle
);

    logic signed [31:0] tokens_reg, tokens_next;
    logic [NOW_W-1:0]   last_time_reg, last_time_next;
    logic [COUNT_W-1:0] suppressed_reg, suppressed_next;

    logic [CAP_W-1:0]        cap;
    logic [NOW_W-1:0]        elapsed;
    logic [41:0]             prod;
    logic signed [43:0]      sum;
    logic signed [31:0]      refilled;
    logic signed [31:0]      t;
    logic                    filtered;
    logic                    dropped;
    logic                    report;

    always_comb
    begin
        cap      = CAP_W'(cfg.burst_tokens * ONE_TOKEN);
        elapsed  = now_ms - last_time_reg;
        prod     = 42'(elapsed) * 42'(cfg.rate_per_second);
        sum      = $signed({{12{tokens_reg[31]}}, tokens_reg}) + $signed({2'b00, prod});
        if (sum > $signed({23'b0, cap}))
            refilled = $signed({11'b0, cap});
        else
            refilled = sum[31:0];

        filtered = level < cfg.level_floor;

        last_time_next  = last_time_reg;
        tokens_next     = tokens_reg;
        suppressed_next = suppressed_reg;

        // Refill: a first request fills the bucket, zero elapsed time changes nothing.
        if (last_time_reg == '0)
        begin
            t              = $signed({11'b0, cap});
            last_time_next = now_ms;
        end
        else if (elapsed == '0)
        begin
            t = tokens_reg;
        end
        else
        begin
            t              = refilled;
            last_time_next = now_ms;
        end

        dropped = t < 32'sd1000;
        report  = (suppressed_reg != '0) && (t >= 32'sd2000);

        bundle.triple = 1'b0;
        bundle.kind   = KIND_PASS;
        bundle.count  = '0;
        bundle.sev    = level;

        if (filtered)
        begin
            bundle.kind    = KIND_FILTER;
            last_time_next = last_time_reg;
        end
        else if (dropped)
        begin
            bundle.kind = KIND_DROP;
            tokens_next = t;
            if (suppressed_reg != '1)
                suppressed_next = suppressed_reg + 1'b1;
        end
        else if (report)
        begin
            bundle.triple   = 1'b1;
            bundle.count    = suppressed_reg;
            tokens_next     = t - 32'sd3000;
            suppressed_next = '0;
        end
        else
        begin
            tokens_next = t - 32'sd1000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tokens_reg     <= '0;
            last_time_reg  <= '0;
            suppressed_reg <= '0;
        end
        else if (go)
        begin
            tokens_reg     <= tokens_next;
            last_time_reg  <= last_time_next;
            suppressed_reg <= suppressed_next;
        end
    end

endmodule

>>> sv/ltbl_out_seq.sv
// Result register and sequencer that hands out the results of one request.
// Depends on ltbl_pkg for the result bundle and kind codes.
module ltbl_out_seq
    import ltbl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  ltbl_bundle_t       bundle,
    output logic               free,
    output logic               tvalid,
    input  logic               tready,
    output logic [TDATA_W-1:0] tdata,
    output logic               tlast,
    output logic [2:0]         tuser
);

    logic               valid_reg, valid_next;
    logic [1:0]         idx_reg, idx_next;
    ltbl_bundle_t       hold_reg;
    kind_t              kind_cur;
    logic [COUNT_W-1:0] count_cur;
    logic               fire;

    always_comb
    begin
        if (hold_reg.triple)
        begin
            unique case (idx_reg)
                2'd0:    kind_cur = KIND_NOTICE;
                2'd1:    kind_cur = KIND_COUNT;
                default: kind_cur = KIND_PASS;
            endcase
        end
        else
        begin
            kind_cur = hold_reg.kind;
        end
        count_cur = (kind_cur == KIND_COUNT) ? hold_reg.count : '0;
        tlast     = !hold_reg.triple || (idx_reg == 2'd2);
        tvalid    = valid_reg;
        tuser     = kind_cur;
        tdata     = {5'b0, hold_reg.sev, count_cur};

        fire = valid_reg && tready;
        free = !valid_reg || (fire && tlast);

        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (fire)
        begin
            if (tlast)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            hold_reg <= bundle;
    end

endmodule

>>> sv/ltbl_checker.sv
// Port-level checker for the log token bucket limiter, bound to the top level.
// Depends on ltbl_pkg and the assertion macros header.
`include "log_token_bucket_limiter_top_macros.svh"

module ltbl_checker
    import ltbl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast,
    input logic [2:0]         m_axis_tuser
);

    logic out_fire;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // A stalled result stays put.
    `LTBL_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // Only the two report results can be non-final within a request.
    `LTBL_ASSERT_NOW(a_nonlast_kind, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == KIND_NOTICE || m_axis_tuser == KIND_COUNT)
    // A notice is always followed directly by the suppressed count.
    `LTBL_ASSERT_NEXT(a_notice_then_count, out_fire && m_axis_tuser == KIND_NOTICE, m_axis_tvalid && m_axis_tuser == KIND_COUNT)
    // The count field is zero on every kind but the count report.
    `LTBL_ASSERT_NOW(a_count_zero, m_axis_tvalid && m_axis_tuser != KIND_COUNT, m_axis_tdata[COUNT_W-1:0] == '0)

endmodule

bind log_token_bucket_limiter_top ltbl_checker u_checker (.*);

>>> test/log_token_bucket_limiter_top_tb.sv
// Testbench for the log token bucket limiter top level: directed table, then
// randomized phases, results checked against a typed row's kind or a cycle-free predictor.
// Depends on ltbl_pkg and log_token_bucket_limiter_top.
`timescale 1ns / 100ps

module log_token_bucket_limiter_top_tb;
    import ltbl_pkg::*;

    typedef struct packed {
        kind_t              kind;
        logic [COUNT_W-1:0] count;
        logic [LEVEL_W-1:0] sev;
        logic               last;
    } log_result_t;

    typedef struct packed {
        logic  typed;
        kind_t kind;
    } stated_kind_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_op_t;

    typedef struct packed {
        row_op_t            op;
        reg_idx_t           idx;
        logic [31:0]        value;
        logic [LEVEL_W-1:0] lvl;
        logic               typed;
        kind_t              kind;
    } row_t;

    localparam int NUM_ROWS = 31;

    // Rows that type their result carry exactly one result with last set.
    localparam row_t DIRECTED [NUM_ROWS] = '{
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd100,        3'd0, 1'b1, KIND_FILTER},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd0,          3'd4, 1'b1, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd0,          3'd1, 1'b1, KIND_PASS},
        '{ROW_CFG, REG_BURST_TOKENS,    32'd3,          3'd0, 1'b0, KIND_PASS},
        '{ROW_CFG, REG_RATE_PER_SECOND, 32'd1000,       3'd0, 1'b0, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd10,         3'd2, 1'b1, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd10,         3'd2, 1'b1, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd10,         3'd3, 1'b1, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd10,         3'd4, 1'b1, KIND_DROP},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd10,         3'd2, 1'b1, KIND_DROP},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd12,         3'd3, 1'b0, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd12,         3'd2, 1'b1, KIND_DROP},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd13,         3'd2, 1'b1, KIND_DROP},
        '{ROW_CFG, REG_LEVEL_FLOOR,     32'd7,          3'd0, 1'b0, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd20,         3'd6, 1'b1, KIND_FILTER},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd20,         3'd7, 1'b0, KIND_PASS},
        '{ROW_CFG, REG_LEVEL_FLOOR,     32'd0,          3'd0, 1'b0, KIND_PASS},
        '{ROW_CFG, REG_BURST_TOKENS,    32'd0,          3'd0, 1'b0, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd30,         3'd0, 1'b1, KIND_DROP},
        '{ROW_CFG, REG_BURST_TOKENS,    32'd2047,       3'd0, 1'b0, KIND_PASS},
        '{ROW_CFG, REG_RATE_PER_SECOND, 32'd0,          3'd0, 1'b0, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd40,         3'd5, 1'b1, KIND_DROP},
        '{ROW_CFG, REG_RATE_PER_SECOND, 32'd1023,       3'd0, 1'b0, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'hFFFF_FFFF,  3'd1, 1'b0, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd3,          3'd3, 1'b0, KIND_PASS},
        '{ROW_CFG, REG_RATE_PER_SECOND, 32'd1,          3'd0, 1'b0, KIND_PASS},
        '{ROW_CFG, REG_BURST_TOKENS,    32'd1,          3'd0, 1'b0, KIND_PASS},
        '{ROW_CFG, REG_LEVEL_FLOOR,     32'd4,          3'd0, 1'b0, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd1000,       3'd4, 1'b1, KIND_PASS},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd1000,       3'd3, 1'b1, KIND_FILTER},
        '{ROW_REQ, REG_LEVEL_FLOOR,     32'd1001,       3'd4, 1'b1, KIND_DROP}
    };

    localparam int NUM_PHASES       = 4;
    localparam int ITEMS_PER_PHASE  = 20;
    localparam int SEND_IDLE [NUM_PHASES]  = '{0, 76, 0, 14};
    localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 76, 14};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  m_axis_tlast;
    logic [2:0]            m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;

    // Predictor copy of the registers and of the bucket state.
    logic [LEVEL_W-1:0]  lim_level_floor = 3'd1;
    logic [BURST_W-1:0]  lim_burst     = 11'd10;
    logic [RATE_W-1:0]   lim_rate      = 10'd20;
    logic signed [31:0]  bucket_milli  = '0;
    logic [NOW_W-1:0]    last_ms       = '0;
    logic [COUNT_W-1:0]  suppressed    = '0;

    log_result_t  request_results[$];
    log_result_t  expected_log_results[$];
    stated_kind_t stated_kinds[$];

    log_token_bucket_limiter_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Refills the bucket for one request and collects the results it causes.
    function automatic void rate_limit_request(input logic [NOW_W-1:0] now,
                                               input logic [LEVEL_W-1:0] lvl);
        longint          cap;
        longint          t;
        logic [NOW_W-1:0] elapsed;
        request_results.delete();
        if (lvl < lim_level_floor)
        begin
            request_results.push_back('{KIND_FILTER, 32'd0, lvl, 1'b1});
            return;
        end
        cap = longint'({53'd0, lim_burst}) * ONE_TOKEN;
        if (last_ms == '0)
        begin
            last_ms      = now;
            bucket_milli = cap[31:0];
        end
        else
        begin
            elapsed = now - last_ms;
            if (elapsed != '0)
            begin
                t = longint'(bucket_milli)
                    + longint'({32'd0, elapsed}) * longint'({54'd0, lim_rate});
                if (t > cap)
                    t = cap;
                bucket_milli = t[31:0];
                last_ms      = now;
            end
        end
        t = longint'(bucket_milli);
        if (t < ONE_TOKEN)
        begin
            if (suppressed != '1)
                suppressed = suppressed + 1;
            request_results.push_back('{KIND_DROP, 32'd0, lvl, 1'b1});
            return;
        end
        // The report costs two tokens and may leave the bucket in debt.
        if (suppressed != '0 && t >= 2 * ONE_TOKEN)
        begin
            request_results.push_back('{KIND_NOTICE, 32'd0, lvl, 1'b0});
            request_results.push_back('{KIND_COUNT, suppressed, lvl, 1'b0});
            t          = t - 2 * ONE_TOKEN;
            suppressed = '0;
        end
        t            = t - ONE_TOKEN;
        bucket_milli = t[31:0];
        request_results.push_back('{KIND_PASS, 32'd0, lvl, 1'b1});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Register writes, accepted requests and results, in that order per edge.
    always @(posedge clk)
    begin : bucket_check
        stated_kind_t stated;
        log_result_t  want;
        logic [LEVEL_W-1:0] req_lvl;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_LEVEL_FLOOR:     lim_level_floor = cfg_data[LEVEL_W-1:0];
                    REG_BURST_TOKENS:    lim_burst       = cfg_data[BURST_W-1:0];
                    REG_RATE_PER_SECOND: lim_rate        = cfg_data[RATE_W-1:0];
                    default:             ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                stated  = stated_kinds.pop_front();
                req_lvl = s_axis_tdata[NOW_W+LEVEL_W-1:NOW_W];
                rate_limit_request(s_axis_tdata[NOW_W-1:0], req_lvl);
                if (stated.typed)
                    expected_log_results.push_back('{stated.kind, 32'd0, req_lvl, 1'b1});
                else
                    foreach (request_results[i])
                        expected_log_results.push_back(request_results[i]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_log_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d count %0d", m_axis_tuser,
                           m_axis_tdata[COUNT_W-1:0]);
                    fail_count++;
                end
                else
                begin
                    want = expected_log_results.pop_front();
                    if (m_axis_tuser !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[COUNT_W-1:0] !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count,
                               m_axis_tdata[COUNT_W-1:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[COUNT_W+LEVEL_W-1:COUNT_W] !== want.sev)
                    begin
                        $error("severity: expected %0d, got %0d", want.sev,
                               m_axis_tdata[COUNT_W+LEVEL_W-1:COUNT_W]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic send_request(input logic [NOW_W-1:0] now, input logic [LEVEL_W-1:0] lvl,
                                input logic typed, input kind_t kind);
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        stated_kinds.push_back('{typed, kind});
        s_axis_tdata  <= {{(TDATA_W-NOW_W-LEVEL_W){1'b0}}, lvl, now};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Drops both valids and waits until every pending result has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b0;
        do
            @(posedge clk);
        while (expected_log_results.size() != 0);
    endtask

    initial
    begin
        logic [NOW_W-1:0]      stamp_ms;
        logic [CFG_DATA_W-1:0] value;
        int                    pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIRECTED[r].op == ROW_CFG)
            begin
                wait_idle();
                write_reg(DIRECTED[r].idx, DIRECTED[r].value[CFG_DATA_W-1:0]);
            end
            else
                send_request(DIRECTED[r].value, DIRECTED[r].lvl, DIRECTED[r].typed,
                             DIRECTED[r].kind);
        end
        stamp_ms = 32'd1001;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];

            if ($urandom_range(0, 9) < 8)
                value = CFG_DATA_W'($urandom_range(0, 4));
            else
                value = CFG_DATA_W'($urandom_range(5, 7));
            write_reg(REG_LEVEL_FLOOR, value);

            pick = $urandom_range(0, 19);
            if (pick < 14)
                value = CFG_DATA_W'($urandom_range(1, 16));
            else if (pick < 17)
                value = CFG_DATA_W'($urandom_range(17, 1024));
            else if (pick == 17)
                value = 11'd1024;
            else if (pick == 18)
                value = 11'd2047;
            else
                value = 11'd0;
            write_reg(REG_BURST_TOKENS, value);

            pick = $urandom_range(0, 19);
            if (pick < 12)
                value = CFG_DATA_W'($urandom_range(1, 60));
            else if (pick < 17)
                value = CFG_DATA_W'($urandom_range(61, 1000));
            else if (pick == 17)
                value = 11'd1000;
            else if (pick == 18)
                value = 11'd1023;
            else
                value = 11'd0;
            write_reg(REG_RATE_PER_SECOND, value);

            // Mostly short steps in time so that bursts, drops and refills interleave.
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    ;
                else if (pick < 85)
                    stamp_ms = stamp_ms + $urandom_range(1, 150);
                else if (pick < 95)
                    stamp_ms = stamp_ms + $urandom_range(151, 20000);
                else
                    stamp_ms = $urandom();
                send_request(stamp_ms, LEVEL_W'($urandom_range(0, 7)), 1'b0, KIND_PASS);
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
